// ===== rtl/ira_pkg.sv =====
// ----------------------------------------------------------------------------
// ira_pkg
// Shared types, kind codes and character constants for the integer to ASCII
// radix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ira_pkg;

  // Conversion kinds
  typedef enum logic [2:0] {
    KIND_SDEC  = 3'd0,
    KIND_UDEC  = 3'd1,
    KIND_OCT   = 3'd2,
    KIND_HEXL  = 3'd3,
    KIND_HEXU  = 3'd4,
    KIND_PTR   = 3'd5
  } kind_t;

  // Input transaction
  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } out_t;

  // Status of the BCD conversion unit
  typedef struct packed {
    logic busy;
    logic done;
  } dab_stat_t;

  localparam int unsigned BIN_W   = 32;
  localparam int unsigned BCD_DIG = 10;
  localparam int unsigned BCD_W   = 4 * BCD_DIG;
  localparam int unsigned DIG_N   = 16;
  localparam int unsigned DIG_W   = 4 * DIG_N;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
  localparam logic [7:0] CH_X     = 8'h78;  // 'x'
  localparam logic [7:0] CH_UBASE = 8'h37;  // 'A' - 10
  localparam logic [7:0] CH_LBASE = 8'h57;  // 'a' - 10

  // One digit value to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    if (d < 4'd10) begin
      base = CH_ZERO;
    end else if (upper) begin
      base = CH_UBASE;
    end else begin
      base = CH_LBASE;
    end
    return base + {4'd0, d};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ira_dabble.sv =====
// ----------------------------------------------------------------------------
// ira_dabble
// Iterative binary to BCD converter: one shift-and-add-3 step per cycle,
// 32 steps per conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_dabble (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load,
  input  wire logic [ira_pkg::BIN_W-1:0]   bin,
  output ira_pkg::dab_stat_t               stat,
  output logic      [ira_pkg::BCD_W-1:0]   bcd
);

  logic [ira_pkg::BIN_W-1:0] bin_r, bin_nxt;
  logic [ira_pkg::BCD_W-1:0] bcd_r, bcd_nxt;
  logic [4:0]                cnt_r, cnt_nxt;
  logic                      run_r, run_nxt;
  logic                      done_r, done_nxt;
  logic [ira_pkg::BCD_W-1:0] adj;

  // Add 3 to every BCD digit of 5 or more (all digits in parallel)
  always_comb begin
    for (int k = 0; k < ira_pkg::BCD_DIG; k++) begin
      if (bcd_r[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd_r[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = bcd_r[4*k +: 4];
      end
    end
  end

  // Step control
  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (load) begin
      bin_nxt = bin;
      bcd_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      bcd_nxt = {adj[ira_pkg::BCD_W-2:0], bin_r[ira_pkg::BIN_W-1]};
      bin_nxt = {bin_r[ira_pkg::BIN_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(ira_pkg::BIN_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = run_r;
  assign stat.done = done_r;
  assign bcd       = bcd_r;

endmodule

`default_nettype wire

// ===== rtl/integer_radix_to_ascii.sv =====
// ----------------------------------------------------------------------------
// integer_radix_to_ascii
// Formats one integer as ASCII text, most significant digit first, one
// character per output strobe, last character flagged.
// ----------------------------------------------------------------------------
// Hex, octal and pointer kinds go straight to leading-zero trim, which shifts
//   one digit per cycle; decimal kinds first pass through the iterative binary
//   to BCD unit. One transaction at a time: start is taken only while idle.
// Kinds 6 and 7 are dropped and the block stays idle. Reset returns to idle
//   with the strobe low.
`default_nettype none

module integer_radix_to_ascii (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire ira_pkg::in_t  in_item,
  output logic               out_valid,
  output ira_pkg::out_t      out_item
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_TRIM,
    S_EMIT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [ira_pkg::DIG_W-1:0]   dig_r, dig_nxt;
  logic [4:0]                  ndig_r, ndig_nxt;
  logic [1:0]                  pfx_r, pfx_nxt;
  logic                        ptr_r, ptr_nxt;
  logic                        upper_r, upper_nxt;
  logic                        out_valid_r, out_valid_nxt;
  ira_pkg::out_t               out_r, out_nxt;

  logic                        accept;
  logic                        dab_load;
  logic [31:0]                 low;
  logic [31:0]                 mag;
  logic [32:0]                 low33;
  logic [43:0]                 oct;
  logic                        neg;
  ira_pkg::dab_stat_t          dab_stat;
  logic [ira_pkg::BCD_W-1:0]   bcd;

  assign accept = start && (state_r == S_IDLE);
  assign low    = in_item.value[31:0];
  assign neg    = (in_item.kind == ira_pkg::KIND_SDEC) && low[31];
  assign mag    = neg ? (~low + 32'd1) : low;
  assign low33  = {1'b0, low};
  assign dab_load = accept && ((in_item.kind == ira_pkg::KIND_SDEC) ||
                               (in_item.kind == ira_pkg::KIND_UDEC));

  // Octal digits regrouped into nibbles, most significant first
  always_comb begin
    for (int k = 0; k < 11; k++) begin
      oct[43-4*k -: 4] = {1'b0, low33[32-3*k -: 3]};
    end
  end

  ira_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (dab_load),
    .bin   (mag),
    .stat  (dab_stat),
    .bcd   (bcd)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    dig_nxt       = dig_r;
    ndig_nxt      = ndig_r;
    pfx_nxt       = pfx_r;
    ptr_nxt       = ptr_r;
    upper_nxt     = upper_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          upper_nxt = (in_item.kind == ira_pkg::KIND_HEXU);
          ptr_nxt   = (in_item.kind == ira_pkg::KIND_PTR);
          pfx_nxt   = 2'd0;
          case (in_item.kind)
            ira_pkg::KIND_SDEC: begin
              pfx_nxt   = neg ? 2'd1 : 2'd0;
              state_nxt = S_CONV;
            end
            ira_pkg::KIND_UDEC: begin
              state_nxt = S_CONV;
            end
            ira_pkg::KIND_OCT: begin
              dig_nxt   = {oct, 20'd0};
              ndig_nxt  = 5'd11;
              state_nxt = S_TRIM;
            end
            ira_pkg::KIND_HEXL, ira_pkg::KIND_HEXU: begin
              dig_nxt   = {low, 32'd0};
              ndig_nxt  = 5'd8;
              state_nxt = S_TRIM;
            end
            ira_pkg::KIND_PTR: begin
              dig_nxt   = in_item.value;
              ndig_nxt  = 5'd16;
              pfx_nxt   = 2'd2;
              state_nxt = S_TRIM;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CONV: begin
        if (dab_stat.done) begin
          dig_nxt   = {bcd, 24'd0};
          ndig_nxt  = 5'd10;
          state_nxt = S_TRIM;
        end
      end
      S_TRIM: begin
        // Drop one leading zero digit per cycle, keep at least one digit
        if ((ndig_r > 5'd1) && (dig_r[63:60] == 4'd0)) begin
          dig_nxt  = {dig_r[59:0], 4'd0};
          ndig_nxt = ndig_r - 5'd1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid_nxt = 1'b1;
        if (pfx_r != 2'd0) begin
          if (!ptr_r) begin
            out_nxt.char_out = ira_pkg::CH_MINUS;
          end else if (pfx_r == 2'd2) begin
            out_nxt.char_out = ira_pkg::CH_ZERO;
          end else begin
            out_nxt.char_out = ira_pkg::CH_X;
          end
          out_nxt.last = 1'b0;
          pfx_nxt      = pfx_r - 2'd1;
        end else begin
          out_nxt.char_out = ira_pkg::digit_char(dig_r[63:60], upper_r);
          out_nxt.last     = (ndig_r == 5'd1);
          dig_nxt          = {dig_r[59:0], 4'd0};
          ndig_nxt         = ndig_r - 5'd1;
          if (ndig_r == 5'd1) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dig_r   <= dig_nxt;
    ndig_r  <= ndig_nxt;
    pfx_r   <= pfx_nxt;
    ptr_r   <= ptr_nxt;
    upper_r <= upper_nxt;
    out_r   <= out_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

// ===== rtl/ira_checker.sv =====
// ----------------------------------------------------------------------------
// ira_checker
// Port-level checks on the converter's command and result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input wire ira_pkg::in_t  in_item,
  input wire logic          out_valid,
  input wire ira_pkg::out_t out_item
);

  // A valid kind makes the block busy, with no character in the first cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.kind <= 3'(ira_pkg::KIND_PTR)) |=> busy && !out_valid)
    else $error("valid transaction did not start conversion");

  // Unused kinds are dropped
  a_bad_kind: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.kind > 3'(ira_pkg::KIND_PTR)) |=> !busy && !out_valid)
    else $error("unused kind was not ignored");

  // Characters of one number leave back to back; busy may already be low
  // while the closing character is shown
  a_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |=> out_valid)
    else $error("gap inside a number's text");

  // Output seen while idle is the closing character
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy |-> out_item.last)
    else $error("non-final character after busy fell");

  // Reset leaves the block idle and quiet
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

endmodule

bind integer_radix_to_ascii ira_checker u_ira_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire

// ===== bench/integer_radix_to_ascii_check.sv =====
// ----------------------------------------------------------------------------
// integer_radix_to_ascii_check
// Watches the command and character channels of the radix converter. Every
// accepted transaction is formatted here as well, and the characters that
// come out are compared in order against that text.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_radix_to_ascii_check
  import ira_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic busy,
  input  wire in_t  in_item,
  input  wire logic out_valid,
  input  wire out_t out_item,
  output int        fail_count,
  output int        pending,
  output int        numbers_taken,
  output int        numbers_ignored,
  output int        chars_checked
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] ASCII_ZERO    = "0";
  localparam logic [7:0] ASCII_MINUS   = "-";
  localparam logic [7:0] ASCII_X       = "x";
  localparam logic [7:0] ASCII_UPPER_A = "A";
  localparam logic [7:0] ASCII_LOWER_A = "a";

  // Characters still owed by the block, oldest first
  out_t expected_chars[$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    numbers_taken   = 0;
    numbers_ignored = 0;
    chars_checked   = 0;
  end

  // Format one number and queue its characters
  task automatic queue_number_text(input in_t item);
    logic [63:0] mag;
    logic [63:0] radix;
    logic        upper;
    logic [3:0]  d;
    logic [7:0]  c;
    logic [7:0]  digits[$];
    logic [7:0]  text[$];
    out_t        ch;
    mag   = {32'd0, item.value[31:0]};
    radix = 64'd10;
    upper = 1'b0;
    case (kind_t'(item.kind))
      KIND_SDEC: begin
        // magnitude taken at 33 bits so the most negative value is exact
        if (item.value[31]) begin
          text.push_back(ASCII_MINUS);
          mag = 64'h1_0000_0000 - mag;
        end
      end
      KIND_UDEC: radix = 64'd10;
      KIND_OCT:  radix = 64'd8;
      KIND_HEXL: radix = 64'd16;
      KIND_HEXU: begin
        radix = 64'd16;
        upper = 1'b1;
      end
      KIND_PTR: begin
        radix = 64'd16;
        mag   = item.value;
        text.push_back(ASCII_ZERO);
        text.push_back(ASCII_X);
      end
      default: begin
        // unused kind: nothing comes out
        numbers_ignored++;
        return;
      end
    endcase
    numbers_taken++;
    // digits come out least significant first; zero still yields one digit
    do begin
      d = 4'(mag % radix);
      if (d < 4'd10) c = ASCII_ZERO + 8'(d);
      else if (upper) c = ASCII_UPPER_A + 8'(d) - 8'd10;
      else c = ASCII_LOWER_A + 8'(d) - 8'd10;
      digits.push_front(c);
      mag = mag / radix;
    end while (mag != 0);
    foreach (digits[i]) text.push_back(digits[i]);
    foreach (text[i]) begin
      ch.char_out = text[i];
      ch.last     = (i == text.size() - 1);
      expected_chars.push_back(ch);
    end
  endtask

  // Compare characters first, then take in a new transaction
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_valid) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          $error("unexpected character: char_out %h last %b",
                 out_item.char_out, out_item.last);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_item.char_out !== want.char_out) begin
            $error("char_out: expected %h, got %h", want.char_out, out_item.char_out);
            fail_count++;
          end
          if (out_item.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_item.last);
            fail_count++;
          end
        end
      end
      if (start && !busy) queue_number_text(in_item);
      pending = expected_chars.size();
    end
  end

endmodule

`default_nettype wire

// ===== bench/integer_radix_to_ascii_test.sv =====
// ----------------------------------------------------------------------------
// integer_radix_to_ascii_test
// Drives the radix converter with directed corner numbers of every kind, then
// with random numbers of varied length and random start gaps, and gives the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_radix_to_ascii_test;

  timeunit 1ns;
  timeprecision 1ps;

  import ira_pkg::*;

  localparam int RANDOM_NUMBERS = 200;
  localparam int CALM_TAIL      = 30;      // last numbers sent without gaps
  localparam int SETTLE_CYCLES  = 100;     // longest decimal latency plus text
  localparam int CYCLE_LIMIT    = 200000;

  logic clk     = 1'b0;
  logic rst_n   = 1'b0;
  logic start   = 1'b0;
  in_t  in_item = '0;
  logic busy;
  logic out_valid;
  out_t out_item;

  int fail_count;
  int pending;
  int numbers_taken;
  int numbers_ignored;
  int chars_checked;
  int cycle_count = 0;

  always #5 clk = ~clk;

  integer_radix_to_ascii DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  integer_radix_to_ascii_check text_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_item        (out_item),
    .fail_count      (fail_count),
    .pending         (pending),
    .numbers_taken   (numbers_taken),
    .numbers_ignored (numbers_ignored),
    .chars_checked   (chars_checked)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("integer_radix_to_ascii_test: done, errors");
      $finish;
    end
  end

  // Hold start with the number until the block takes it
  task automatic send_number(input in_t item);
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending and let every owed character come out
  task automatic drain_text;
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    in_t         directed[$];
    in_t         item;
    logic [63:0] full;
    int          sent;
    bit          paused;

    directed = '{
      '{kind: KIND_SDEC, value: 64'd0},
      '{kind: KIND_SDEC, value: 64'h0000_0000_7fff_ffff},
      '{kind: KIND_SDEC, value: 64'h0000_0000_8000_0000},
      '{kind: KIND_SDEC, value: 64'h0000_0000_ffff_ffff},
      '{kind: KIND_SDEC, value: 64'hdead_beef_0000_007b},
      '{kind: KIND_UDEC, value: 64'd0},
      '{kind: KIND_UDEC, value: 64'h0000_0000_ffff_ffff},
      '{kind: KIND_UDEC, value: 64'hffff_ffff_0000_0009},
      '{kind: KIND_OCT,  value: 64'd0},
      '{kind: KIND_OCT,  value: 64'd8},
      '{kind: KIND_OCT,  value: 64'hffff_ffff_ffff_ffff},
      '{kind: KIND_HEXL, value: 64'd0},
      '{kind: KIND_HEXL, value: 64'h0000_0000_abcd_ef09},
      '{kind: KIND_HEXL, value: 64'h1234_5678_ffff_ffff},
      '{kind: KIND_HEXU, value: 64'd0},
      '{kind: KIND_HEXU, value: 64'h0000_0000_abcd_ef12},
      '{kind: KIND_PTR,  value: 64'd0},
      '{kind: KIND_PTR,  value: 64'hffff_ffff_ffff_ffff},
      '{kind: KIND_PTR,  value: 64'h8000_0000_0000_0000},
      '{kind: KIND_PTR,  value: 64'h0123_4567_89ab_cdef},
      '{kind: 3'd6,      value: 64'h5555_aaaa_5555_aaaa},
      '{kind: 3'd7,      value: 64'haaaa_5555_aaaa_5555},
      '{kind: KIND_HEXU, value: 64'h0000_0000_0000_000f}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners, back to back
    foreach (directed[i]) send_number(directed[i]);
    drain_text();

    // Random numbers of varied length; a few unused kinds as noise
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_NUMBERS) begin
      full = {$urandom(), $urandom()};
      if ($urandom_range(0, 99) < 8) item.kind = 3'($urandom_range(6, 7));
      else item.kind = 3'($urandom_range(0, 5));
      case ($urandom_range(0, 4))
        0: item.value = full;
        1: item.value = full >> $urandom_range(0, 63);
        2: item.value = {full[63:32], 32'($urandom_range(0, 20))};
        3: item.value = {full[63:32], 32'hffff_ffff - 32'($urandom_range(0, 20))};
        default: item.value = {full[63:32], 32'h8000_0000 | (full[31:0] >> $urandom_range(1, 31))};
      endcase
      send_number(item);
      if (item.kind <= 3'd5) sent++;

      if (!paused && sent >= RANDOM_NUMBERS / 2) begin
        paused = 1'b1;
        drain_text();
      end else if (sent < RANDOM_NUMBERS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end

    // Wind down
    drain_text();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (pending != 0) $error("%0d characters never came out", pending);

    $display("converted %0d numbers across all kinds, %0d unused-kind commands ignored",
             numbers_taken, numbers_ignored);
    $display("%0d characters compared", chars_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("integer_radix_to_ascii_test: done, clean");
    end else begin
      $display("integer_radix_to_ascii_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== integer_radix_to_ascii.f =====
rtl/ira_pkg.sv
rtl/ira_dabble.sv
rtl/integer_radix_to_ascii.sv
rtl/ira_checker.sv
bench/integer_radix_to_ascii_check.sv
bench/integer_radix_to_ascii_test.sv
